/* design/stereo_ring_resampler_fifo_assert.svh */
// Assertion macros shared by the checker of the stereo ring resampler FIFO.
`ifndef STEREO_RING_RESAMPLER_FIFO_ASSERT_SVH
`define STEREO_RING_RESAMPLER_FIFO_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SRRF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SRRF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* design/srrf_pkg.sv */
// Types, codes and constants of the stereo ring resampler FIFO.
`timescale 1ns / 1ps
package srrf_pkg;

	localparam int unsigned RING_FRAMES_DEF     = 32768;
	localparam int unsigned HEADROOM_FRAMES_DEF = 1024;
	localparam int unsigned BLOCK_FRAMES_DEF    = 256;

	// Q16 read steps: one frame per pull, or 32 kHz source played at 48 kHz.
	localparam logic [16:0] STEP_FULL = 17'd65536;
	localparam logic [16:0] STEP_SLOW = 17'((64'd32000 << 16) / 64'd48000);

	localparam logic [31:0] FILL_MAX = 32'd32768;

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_PULL  = 3'd1,
		OP_START = 3'd2,
		OP_STOP  = 3'd3,
		OP_RESET = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	localparam logic [1:0] CFG_RATE_IS_48K  = 2'd0;
	localparam logic [1:0] CFG_CALLBACK_REG = 2'd1;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
		logic               last_frame;
		logic [17:0]        buffer_bytes;
	} srrf_in_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic               underrun;
		logic               callback_fire;
		logic [17:0]        bytes_left;
		logic [15:0]        fill_frames;
		logic [31:0]        sample_count;
		logic               transfer_on;
	} srrf_out_t;

endpackage

/* design/srrf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module srrf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/stereo_ring_resampler_fifo.sv */
// Pipeline: an item passes through the input register, then the result register.
// Throughput: one item per cycle while the result is not stalled; the ring sits in one block
// RAM with a registered read port; read position, write count and mark are updated per item.
// Reset (arst_n low) clears all control and state registers at once; the ring contents are
// not cleared and need no clearing pass, so items are taken right after reset.
`timescale 1ns / 1ps
module stereo_ring_resampler_fifo #(
	parameter int unsigned RING_FRAMES     = srrf_pkg::RING_FRAMES_DEF,
	parameter int unsigned HEADROOM_FRAMES = srrf_pkg::HEADROOM_FRAMES_DEF,
	parameter int unsigned BLOCK_FRAMES    = srrf_pkg::BLOCK_FRAMES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  srrf_pkg::srrf_in_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output srrf_pkg::srrf_out_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic                cfg_data
);

	import srrf_pkg::*;

	localparam int unsigned AW = $clog2(RING_FRAMES);
	localparam int unsigned PW = $clog2(BLOCK_FRAMES + 1);
	localparam logic [31:0] OVF_LIMIT = 32'(RING_FRAMES - HEADROOM_FRAMES);
	localparam logic [31:0] HEADROOM  = 32'(HEADROOM_FRAMES);
	localparam logic [31:0] BLOCK_ADD = 32'(BLOCK_FRAMES);
	localparam logic [PW-1:0] BLOCK_W = PW'(BLOCK_FRAMES);

	// Pipeline registers.
	srrf_in_t item_s1;
	logic     valid_s1;
	logic     valid_s2;
	logic     pull_ok_s2;
	logic     underrun_s2;
	logic     fire_s2;

	// Architectural state.
	logic [31:0]   write_count_q;
	logic [47:0]   read_pos_q;
	logic [47:0]   mark_pos_q;
	logic          mark_armed_q;
	logic          enabled_q;
	logic [17:0]   stored_len_q;
	logic [PW-1:0] phase_q;
	logic [31:0]   out_count_q;
	logic          rate_48k_q;
	logic          cb_reg_q;

	// Next state.
	logic [31:0]   write_count_d;
	logic [47:0]   read_pos_d;
	logic [47:0]   mark_pos_d;
	logic          mark_armed_d;
	logic          enabled_d;
	logic [17:0]   stored_len_d;
	logic [PW-1:0] phase_d;
	logic [31:0]   out_count_d;
	logic          underrun_d;
	logic          fire_d;

	logic          s2_free;
	logic          adv_s1;
	logic          item_accept;
	logic          cfg_we;
	logic [31:0]   wc_inc;
	logic [31:0]   read_frame;
	logic          pull_ok;
	logic [16:0]   step;
	logic [47:0]   read_pos_step;
	logic [PW-1:0] phase_inc;
	logic          ram_we;
	logic          ram_re;
	logic [31:0]   ram_rdata;
	logic [31:0]   fill_raw;
	logic [31:0]   mark_frame;
	logic [31:0]   frame_diff;
	logic [17:0]   rem_bytes;
	logic [17:0]   bytes_left;

	// Handshake: the input register advances whenever the result register is free.
	assign s2_free     = !valid_s2 || !result_stall;
	assign adv_s1      = valid_s1 && s2_free;
	assign item_stall  = valid_s1 && !s2_free;
	assign item_accept = item_valid && !item_stall;
	assign cfg_ready   = !valid_s1 && !valid_s2;
	assign cfg_we      = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			item_s1 <= item;
		end
		if (adv_s1) begin
			pull_ok_s2  <= (item_s1.op == OP_PULL) && pull_ok;
			underrun_s2 <= underrun_d;
			fire_s2     <= fire_d;
		end
	end

	assign wc_inc        = write_count_q + 32'd1;
	assign read_frame    = read_pos_q[47:16];
	assign pull_ok       = write_count_q != read_frame;
	assign step          = rate_48k_q ? STEP_FULL : STEP_SLOW;
	assign read_pos_step = read_pos_q + 48'(step);
	assign phase_inc     = phase_q + PW'(1);

	always_comb begin
		write_count_d = write_count_q;
		read_pos_d    = read_pos_q;
		mark_pos_d    = mark_pos_q;
		mark_armed_d  = mark_armed_q;
		enabled_d     = enabled_q;
		stored_len_d  = stored_len_q;
		phase_d       = phase_q;
		out_count_d   = out_count_q;
		underrun_d    = 1'b0;
		fire_d        = 1'b0;
		unique case (item_s1.op)
			OP_PUSH: begin
				write_count_d = wc_inc;
				if (item_s1.last_frame) begin
					stored_len_d = item_s1.buffer_bytes;
					// Too far behind the writer: drop back to the headroom distance.
					if ((wc_inc - read_frame) > OVF_LIMIT) begin
						read_pos_d = {wc_inc - HEADROOM, 16'h0000};
					end
					if (cb_reg_q && (item_s1.buffer_bytes != 18'd0)) begin
						mark_pos_d   = {wc_inc, 16'h0000};
						mark_armed_d = 1'b1;
					end
				end
			end
			OP_PULL: begin
				if (pull_ok) begin
					read_pos_d = read_pos_step;
				end
				underrun_d = !pull_ok;
				if (phase_inc >= BLOCK_W) begin
					phase_d     = '0;
					out_count_d = out_count_q + BLOCK_ADD;
					if (mark_armed_q && (read_pos_d >= mark_pos_q)) begin
						mark_armed_d = 1'b0;
						fire_d       = cb_reg_q;
					end
				end else begin
					phase_d = phase_inc;
				end
			end
			OP_START: begin
				enabled_d = 1'b1;
				if (cb_reg_q && (stored_len_q != 18'd0)) begin
					mark_pos_d   = {write_count_q, 16'h0000};
					mark_armed_d = 1'b1;
				end
			end
			OP_STOP: begin
				enabled_d = 1'b0;
			end
			OP_RESET: begin
				enabled_d     = 1'b0;
				stored_len_d  = '0;
				out_count_d   = '0;
				write_count_d = '0;
				read_pos_d    = '0;
				mark_armed_d  = 1'b0;
			end
			OP_CLEAR: begin
				out_count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_count_q <= '0;
			read_pos_q    <= '0;
			mark_pos_q    <= '0;
			mark_armed_q  <= 1'b0;
			enabled_q     <= 1'b0;
			stored_len_q  <= '0;
			phase_q       <= '0;
			out_count_q   <= '0;
			rate_48k_q    <= 1'b0;
			cb_reg_q      <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_RATE_IS_48K) begin
				rate_48k_q <= cfg_data;
			end else if (cfg_index == CFG_CALLBACK_REG) begin
				cb_reg_q <= cfg_data;
				if (cfg_data && (stored_len_q != 18'd0)) begin
					mark_pos_q   <= {write_count_q, 16'h0000};
					mark_armed_q <= 1'b1;
				end
			end
		end else if (adv_s1) begin
			write_count_q <= write_count_d;
			read_pos_q    <= read_pos_d;
			mark_pos_q    <= mark_pos_d;
			mark_armed_q  <= mark_armed_d;
			enabled_q     <= enabled_d;
			stored_len_q  <= stored_len_d;
			phase_q       <= phase_d;
			out_count_q   <= out_count_d;
		end
	end

	// A push writes and a pull reads at the transfer into the result register, so a frame
	// pushed by one item is already in the ring for the pull that follows it.
	assign ram_we = adv_s1 && (item_s1.op == OP_PUSH);
	assign ram_re = adv_s1 && (item_s1.op == OP_PULL);

	srrf_ram #(
		.WIDTH(32),
		.DEPTH(RING_FRAMES)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(write_count_q[AW-1:0]),
		.wdata({item_s1.right_in, item_s1.left_in}),
		.re   (ram_re),
		.raddr(read_frame[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Status fields come from the state, which holds the result item's outcome while it waits.
	assign fill_raw   = write_count_q - read_frame;
	assign mark_frame = mark_pos_q[47:16];
	assign frame_diff = mark_frame - read_frame;
	assign rem_bytes  = {frame_diff[15:0], 2'b00};

	always_comb begin
		bytes_left = '0;
		if (enabled_q && mark_armed_q && (mark_frame > read_frame)) begin
			if ((frame_diff[31:16] != 16'd0) || (rem_bytes > stored_len_q)) begin
				bytes_left = stored_len_q;
			end else begin
				bytes_left = rem_bytes;
			end
		end
	end

	assign result_valid         = valid_s2;
	assign result.left_out      = pull_ok_s2 ? ram_rdata[15:0] : 16'sd0;
	assign result.right_out     = pull_ok_s2 ? ram_rdata[31:16] : 16'sd0;
	assign result.underrun      = underrun_s2;
	assign result.callback_fire = fire_s2;
	assign result.bytes_left    = bytes_left;
	assign result.fill_frames   = (fill_raw > FILL_MAX) ? FILL_MAX[15:0] : fill_raw[15:0];
	assign result.sample_count  = out_count_q;
	assign result.transfer_on   = enabled_q;

endmodule

/* design/srrf_checker.sv */
// Port-level checker for the stereo ring resampler FIFO, bound to its top level.
`timescale 1ns / 1ps
`include "stereo_ring_resampler_fifo_assert.svh"
module srrf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_stall,
	input logic                result_valid,
	input logic                result_stall,
	input srrf_pkg::srrf_out_t result
);

	import srrf_pkg::*;

	`SRRF_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
	`SRRF_ASSERT_IMP(a_stall_cause, item_stall, result_valid && result_stall, "input stalled while output free")
	`SRRF_ASSERT_IMP(a_underrun_silent, result_valid && result.underrun, (result.left_out == 16'sd0) && (result.right_out == 16'sd0), "underrun without silence")
	`SRRF_ASSERT_IMP(a_fill_sat, result_valid, result.fill_frames <= FILL_MAX[15:0], "fill count above saturation")
	`SRRF_ASSERT_IMP(a_bytes_idle, result_valid && (result.bytes_left != 18'd0), result.transfer_on, "bytes left reported while transfer off")

endmodule

bind stereo_ring_resampler_fifo srrf_checker u_srrf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_stall  (item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
